[rtl/tppc_pkg.sv]
`default_nettype none
package tppc_pkg;

  localparam int PERIOD_BITS     = 16;
  localparam int PRESCALER_STEPS = 8;

  localparam int CLK_W  = 28;
  localparam int US_W   = 32;
  localparam int PROD_W = CLK_W + US_W;
  localparam int REM_W  = 20;
  localparam int Q_W    = 41;
  localparam int CNT_W  = 6;
  localparam int SH_W   = 4;
  localparam int IDX_W  = 3;

  localparam logic [CLK_W-1:0] CLK_RESET = CLK_W'(80000000);
  localparam logic [REM_W:0]   US_PER_S  = (REM_W + 1)'(1000000);
  localparam logic [Q_W-1:0]   TICK_LIMIT = Q_W'(1) << PERIOD_BITS;

  localparam logic [2:0] CH_FIRST = 3'd1;
  localparam logic [2:0] CH_LAST  = 3'd5;

  localparam logic [IDX_W-1:0] CH1_LAST_IDX = IDX_W'(4 - 1);
  localparam logic [IDX_W-1:0] CHX_LAST_IDX =
    IDX_W'(((PRESCALER_STEPS > 8) ? 8 : PRESCALER_STEPS) - 1);

  typedef enum logic [2:0] {
    S_IDLE,
    S_MUL,
    S_DIV,
    S_SRCH,
    S_OUT
  } state_t;

  typedef struct packed {
    logic [2:0]  irq_priority_out;
    logic        irq_enable_out;
    logic [15:0] period_value;
    logic [2:0]  prescaler_code;
    logic        ok;
  } result_t;

  // divisors are powers of two: return log2 of the table entry
  function automatic logic [SH_W-1:0] div_shift(input logic ch1, input logic [IDX_W-1:0] idx);
    logic [SH_W-1:0] s;
    if (ch1) begin
      unique case (idx)
        3'd0:    s = 4'd0;
        3'd1:    s = 4'd3;
        3'd2:    s = 4'd6;
        default: s = 4'd8;
      endcase
    end else begin
      unique case (idx)
        3'd7:    s = 4'd8;
        default: s = {1'b0, idx};
      endcase
    end
    return s;
  endfunction

endpackage
`default_nettype wire

[rtl/tppc_mul.sv]
`default_nettype none
module tppc_mul (
  input  wire logic                              clk,
  input  wire logic                              rst_n,
  input  wire logic                              start,
  input  wire logic [tppc_pkg::CLK_W-1:0]        a,
  input  wire logic [tppc_pkg::US_W-1:0]         b,
  output logic                                   done,
  output logic [tppc_pkg::PROD_W-1:0]            product
);

  logic [tppc_pkg::PROD_W:0]   p_r, p_nxt;
  logic [tppc_pkg::CNT_W-1:0]  cnt_r, cnt_nxt;
  logic                        busy_r, busy_nxt;
  logic                        done_r, done_nxt;
  logic [tppc_pkg::CLK_W:0]    sum;

  // shift-add, one multiplier bit per cycle, LSB first
  always_comb begin
    sum = {1'b0, p_r[tppc_pkg::PROD_W-1:tppc_pkg::US_W]}
        + (p_r[0] ? {1'b0, a} : '0);
    p_nxt    = p_r;
    cnt_nxt  = cnt_r;
    busy_nxt = busy_r;
    done_nxt = 1'b0;
    if (start) begin
      p_nxt    = {(tppc_pkg::CLK_W + 1)'(0), b};
      cnt_nxt  = '0;
      busy_nxt = 1'b1;
    end else if (busy_r) begin
      p_nxt   = {1'b0, sum, p_r[tppc_pkg::US_W-1:1]};
      cnt_nxt = cnt_r + 1'b1;
      if (cnt_r == tppc_pkg::CNT_W'(tppc_pkg::US_W - 1)) begin
        busy_nxt = 1'b0;
        done_nxt = 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    p_r   <= p_nxt;
    cnt_r <= cnt_nxt;
    if (!rst_n) begin
      busy_r <= 1'b0;
      done_r <= 1'b0;
    end else begin
      busy_r <= busy_nxt;
      done_r <= done_nxt;
    end
  end

  assign done    = done_r;
  assign product = p_r[tppc_pkg::PROD_W-1:0];

endmodule
`default_nettype wire

[rtl/tppc_div.sv]
`default_nettype none
module tppc_div (
  input  wire logic                              clk,
  input  wire logic                              rst_n,
  input  wire logic                              start,
  input  wire logic [tppc_pkg::PROD_W-1:0]       dividend,
  output logic                                   done,
  output logic [tppc_pkg::Q_W-1:0]               quotient
);

  logic [tppc_pkg::PROD_W-1:0] d_r, d_nxt;
  logic [tppc_pkg::REM_W-1:0]  rem_r, rem_nxt;
  logic [tppc_pkg::CNT_W-1:0]  cnt_r, cnt_nxt;
  logic                        busy_r, busy_nxt;
  logic                        done_r, done_nxt;
  logic [tppc_pkg::REM_W:0]    trial;
  logic [tppc_pkg::REM_W:0]    diff;
  logic                        ge;

  // restoring division by 1e6, one quotient bit per cycle
  always_comb begin
    trial = {rem_r, d_r[tppc_pkg::PROD_W-1]};
    ge    = trial >= tppc_pkg::US_PER_S;
    diff  = trial - tppc_pkg::US_PER_S;
    d_nxt    = d_r;
    rem_nxt  = rem_r;
    cnt_nxt  = cnt_r;
    busy_nxt = busy_r;
    done_nxt = 1'b0;
    if (start) begin
      d_nxt    = dividend;
      rem_nxt  = '0;
      cnt_nxt  = '0;
      busy_nxt = 1'b1;
    end else if (busy_r) begin
      d_nxt   = {d_r[tppc_pkg::PROD_W-2:0], ge};
      rem_nxt = ge ? diff[tppc_pkg::REM_W-1:0] : trial[tppc_pkg::REM_W-1:0];
      cnt_nxt = cnt_r + 1'b1;
      if (cnt_r == tppc_pkg::CNT_W'(tppc_pkg::PROD_W - 1)) begin
        busy_nxt = 1'b0;
        done_nxt = 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    d_r   <= d_nxt;
    rem_r <= rem_nxt;
    cnt_r <= cnt_nxt;
    if (!rst_n) begin
      busy_r <= 1'b0;
      done_r <= 1'b0;
    end else begin
      busy_r <= busy_nxt;
      done_r <= done_nxt;
    end
  end

  assign done     = done_r;
  assign quotient = d_r[tppc_pkg::Q_W-1:0];

endmodule
`default_nettype wire

[rtl/timer_prescaler_period_calculator_core.sv]
// channel | handshake                     | payload
// in      | in_tvalid / in_tready         | in_tdata  (40 b)
// out     | out_tvalid / out_tready       | out_tdata (24 b)
// cfg     | cfg_valid / cfg_ready         | cfg_data  (28 b, bus_clock_hz)
//
// One request at a time: serial multiply, handoff, serial divide by 1e6, handoff,
// prescaler search, then the output register is loaded; out_tvalid rises and
// in_tready returns in the same cycle. Multiply and divide are bit-serial units.
// Reset: synchronous, active low; bus clock returns to 80 MHz.
// A result waiting on out_tready holds the next result, and so the block, in its output state.
`default_nettype none
module timer_prescaler_period_calculator_core (
  input  wire logic        clk,
  input  wire logic        rst_n,
  input  wire logic        in_tvalid,
  output logic             in_tready,
  // [2:0] channel, [34:3] period_us, [35] irq_enable, [38:36] irq_priority
  input  wire logic [39:0] in_tdata,
  output logic             out_tvalid,
  input  wire logic        out_tready,
  // [0] ok, [3:1] prescaler_code, [19:4] period_value,
  // [20] irq_enable_out, [23:21] irq_priority_out
  output logic [23:0]      out_tdata,
  input  wire logic        cfg_valid,
  output logic             cfg_ready,
  input  wire logic [27:0] cfg_data
);

  tppc_pkg::state_t               state_r, state_nxt;
  logic [tppc_pkg::CLK_W-1:0]     bus_clk_r;
  logic [2:0]                     ch_r, ch_nxt;
  logic                           irq_en_r, irq_en_nxt;
  logic [2:0]                     irq_pri_r, irq_pri_nxt;
  logic [tppc_pkg::IDX_W-1:0]     idx_r, idx_nxt;
  tppc_pkg::result_t              res_r, res_nxt;
  tppc_pkg::result_t              out_r, out_nxt;
  logic                           out_valid_r, out_valid_nxt;

  logic                           mul_start, mul_done;
  logic [tppc_pkg::PROD_W-1:0]    product;
  logic                           div_start, div_done;
  logic [tppc_pkg::Q_W-1:0]       q;
  logic [tppc_pkg::Q_W-1:0]       ticks;
  logic [tppc_pkg::Q_W-1:0]       ticks_m1;
  logic                           ch1, ch_ok, fits, last;

  assign cfg_ready = 1'b1;
  assign in_tready = (state_r == tppc_pkg::S_IDLE);

  tppc_mul u_mul (
    .clk     (clk),
    .rst_n   (rst_n),
    .start   (mul_start),
    .a       (bus_clk_r),
    .b       (in_tdata[34:3]),
    .done    (mul_done),
    .product (product)
  );

  tppc_div u_div (
    .clk      (clk),
    .rst_n    (rst_n),
    .start    (div_start),
    .dividend (product),
    .done     (div_done),
    .quotient (q)
  );

  always_comb begin
    ch1      = (ch_r == tppc_pkg::CH_FIRST);
    ch_ok    = (ch_r >= tppc_pkg::CH_FIRST) && (ch_r <= tppc_pkg::CH_LAST);
    ticks    = q >> tppc_pkg::div_shift(ch1, idx_r);
    ticks_m1 = ticks - 1'b1;
    fits     = ticks <= tppc_pkg::TICK_LIMIT;
    last     = ch1 ? (idx_r == tppc_pkg::CH1_LAST_IDX) : (idx_r == tppc_pkg::CHX_LAST_IDX);

    state_nxt     = state_r;
    ch_nxt        = ch_r;
    irq_en_nxt    = irq_en_r;
    irq_pri_nxt   = irq_pri_r;
    idx_nxt       = idx_r;
    res_nxt       = res_r;
    out_nxt       = out_r;
    out_valid_nxt = out_valid_r && !out_tready;
    mul_start     = 1'b0;
    div_start     = 1'b0;

    unique case (state_r)
      tppc_pkg::S_IDLE: begin
        if (in_tvalid) begin
          mul_start   = 1'b1;
          ch_nxt      = in_tdata[2:0];
          irq_en_nxt  = in_tdata[35];
          irq_pri_nxt = in_tdata[38:36];
          state_nxt   = tppc_pkg::S_MUL;
        end
      end
      tppc_pkg::S_MUL: begin
        if (mul_done) begin
          div_start = 1'b1;
          state_nxt = tppc_pkg::S_DIV;
        end
      end
      tppc_pkg::S_DIV: begin
        idx_nxt = '0;
        if (div_done) begin
          state_nxt = tppc_pkg::S_SRCH;
        end
      end
      tppc_pkg::S_SRCH: begin
        res_nxt = '0;
        if (!ch_ok) begin
          state_nxt = tppc_pkg::S_OUT;
        end else if (fits) begin
          if (ticks != '0) begin
            res_nxt.ok               = 1'b1;
            res_nxt.prescaler_code   = idx_r;
            res_nxt.period_value     = ticks_m1[15:0];
            res_nxt.irq_enable_out   = irq_en_r;
            res_nxt.irq_priority_out = irq_pri_r;
          end
          state_nxt = tppc_pkg::S_OUT;
        end else if (last) begin
          state_nxt = tppc_pkg::S_OUT;
        end else begin
          idx_nxt = idx_r + 1'b1;
        end
      end
      tppc_pkg::S_OUT: begin
        if (!out_valid_r || out_tready) begin
          out_nxt       = res_r;
          out_valid_nxt = 1'b1;
          state_nxt     = tppc_pkg::S_IDLE;
        end
      end
      default: state_nxt = tppc_pkg::S_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    ch_r      <= ch_nxt;
    irq_en_r  <= irq_en_nxt;
    irq_pri_r <= irq_pri_nxt;
    idx_r     <= idx_nxt;
    res_r     <= res_nxt;
    out_r     <= out_nxt;
    if (!rst_n) begin
      state_r     <= tppc_pkg::S_IDLE;
      out_valid_r <= 1'b0;
      bus_clk_r   <= tppc_pkg::CLK_RESET;
    end else begin
      state_r     <= state_nxt;
      out_valid_r <= out_valid_nxt;
      if (cfg_valid) begin
        bus_clk_r <= cfg_data;
      end
    end
  end

  assign out_tvalid = out_valid_r;
  assign out_tdata  = out_r;

endmodule
`default_nettype wire

[tb/prescaler_setting_checker.sv]
module prescaler_setting_checker (
  input  wire logic        clk,
  input  wire logic        rst_n,
  input  wire logic        in_tvalid,
  input  wire logic        in_tready,
  input  wire logic [39:0] in_tdata,
  input  wire logic        out_tvalid,
  input  wire logic        out_tready,
  input  wire logic [23:0] out_tdata,
  input  wire logic        cfg_valid,
  input  wire logic        cfg_ready,
  input  wire logic [27:0] cfg_data,
  output int               fail_cnt,
  output int               open_cnt,
  output int               checked_cnt,
  output int               found_cnt
);
  timeunit 1ns;
  timeprecision 1ps;

  localparam logic [27:0] BUS_HZ_AT_RESET = 28'd80_000_000;
  localparam logic [2:0]  SLOW_CH         = 3'd1;
  localparam logic [2:0]  FIRST_VALID_CH  = 3'd1;
  localparam logic [2:0]  LAST_VALID_CH   = 3'd5;
  localparam logic [63:0] US_PER_SEC      = 64'd1_000_000;

  logic [27:0]       bus_hz;
  tppc_pkg::result_t pending_settings[$];

  function automatic int unsigned divisor_at(input bit slow_ch, input int idx);
    if (slow_ch) begin
      case (idx)
        0:       return 1;
        1:       return 8;
        2:       return 64;
        default: return 256;
      endcase
    end
    case (idx)
      0:       return 1;
      1:       return 2;
      2:       return 4;
      3:       return 8;
      4:       return 16;
      5:       return 32;
      6:       return 64;
      default: return 256;
    endcase
  endfunction

  function automatic tppc_pkg::result_t calc_prescaler_setting(input logic [27:0] hz,
      input logic [2:0] ch, input logic [31:0] us, input logic en, input logic [2:0] pri);
    tppc_pkg::result_t r;
    logic [63:0]       prod;
    logic [63:0]       ticks;
    int unsigned       steps;
    bit                hit;
    r = '0;
    ticks = '0;
    hit = 1'b0;
    if (ch < FIRST_VALID_CH || ch > LAST_VALID_CH) return r;
    steps = (ch == SLOW_CH) ? 4 :
            ((tppc_pkg::PRESCALER_STEPS > 8) ? 8 : tppc_pkg::PRESCALER_STEPS);
    prod = 64'(hz) * 64'(us);
    for (int i = 0; i < int'(steps) && !hit; i++) begin
      ticks = prod / (US_PER_SEC * 64'(divisor_at(ch == SLOW_CH, i)));
      if (ticks <= (64'd1 << tppc_pkg::PERIOD_BITS)) begin
        hit = 1'b1;
        r.prescaler_code = 3'(i);
      end
    end
    if (!hit || ticks == 0) return '0;
    r.ok = 1'b1;
    r.period_value = 16'(ticks - 1);
    r.irq_enable_out = en;
    r.irq_priority_out = pri;
    return r;
  endfunction

  always @(posedge clk) begin : watch
    tppc_pkg::result_t want;
    tppc_pkg::result_t got;
    int                errs;
    errs = 0;
    if (!rst_n) begin
      bus_hz <= BUS_HZ_AT_RESET;
      pending_settings.delete();
      fail_cnt <= 0;
      open_cnt <= 0;
      checked_cnt <= 0;
      found_cnt <= 0;
    end else begin
      if (cfg_valid && cfg_ready) bus_hz <= cfg_data;
      if (out_tvalid && out_tready) begin
        got = out_tdata;
        if (pending_settings.size() == 0) begin
          $error("result %h with no request outstanding", out_tdata);
          errs++;
        end else begin
          want = pending_settings.pop_front();
          if (got.ok !== want.ok) begin
            $error("ok: expected %0d, got %0d", want.ok, got.ok);
            errs++;
          end
          if (got.prescaler_code !== want.prescaler_code) begin
            $error("prescaler_code: expected %0d, got %0d",
                   want.prescaler_code, got.prescaler_code);
            errs++;
          end
          if (got.period_value !== want.period_value) begin
            $error("period_value: expected %0d, got %0d",
                   want.period_value, got.period_value);
            errs++;
          end
          if (got.irq_enable_out !== want.irq_enable_out) begin
            $error("irq_enable_out: expected %0d, got %0d",
                   want.irq_enable_out, got.irq_enable_out);
            errs++;
          end
          if (got.irq_priority_out !== want.irq_priority_out) begin
            $error("irq_priority_out: expected %0d, got %0d",
                   want.irq_priority_out, got.irq_priority_out);
            errs++;
          end
          if (want.ok) found_cnt <= found_cnt + 1;
        end
        checked_cnt <= checked_cnt + 1;
      end
      if (in_tvalid && in_tready)
        pending_settings.push_back(calc_prescaler_setting(bus_hz, in_tdata[2:0],
            in_tdata[34:3], in_tdata[35], in_tdata[38:36]));
      fail_cnt <= fail_cnt + errs;
      open_cnt <= pending_settings.size();
    end
  end

endmodule

[tb/tb_timer_prescaler_period_calculator_core.sv]
module tb_timer_prescaler_period_calculator_core;
  timeunit 1ns;
  timeprecision 1ps;

  localparam int NUM_PHASES    = 11;
  localparam int REQ_PER_PHASE = 123;
  localparam int CYCLE_LIMIT   = 3_000_000;
  localparam int DRAIN_CYCLES  = 120;

  logic        clk;
  logic        rst_n      = 1'b0;
  logic        in_tvalid  = 1'b0;
  logic        in_tready;
  logic [39:0] in_tdata   = '0;
  logic        out_tvalid;
  logic        out_tready = 1'b0;
  logic [23:0] out_tdata;
  logic        cfg_valid  = 1'b0;
  logic        cfg_ready;
  logic [27:0] cfg_data   = '0;

  int fail_cnt;
  int open_cnt;
  int checked_cnt;
  int found_cnt;

  logic [27:0] cur_hz       = 28'd80_000_000;
  int          burst_left   = 0;
  int          cycle_cnt    = 0;
  int unsigned rx_left      = 0;
  int unsigned rx_kind      = 0;

  initial begin
    clk = 1'b0;
    forever #5 clk = ~clk;
  end

  timer_prescaler_period_calculator_core i_dut (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_tvalid (in_tvalid),
    .in_tready (in_tready),
    .in_tdata  (in_tdata),
    .out_tvalid(out_tvalid),
    .out_tready(out_tready),
    .out_tdata (out_tdata),
    .cfg_valid (cfg_valid),
    .cfg_ready (cfg_ready),
    .cfg_data  (cfg_data)
  );

  prescaler_setting_checker i_checker (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_tvalid  (in_tvalid),
    .in_tready  (in_tready),
    .in_tdata   (in_tdata),
    .out_tvalid (out_tvalid),
    .out_tready (out_tready),
    .out_tdata  (out_tdata),
    .cfg_valid  (cfg_valid),
    .cfg_ready  (cfg_ready),
    .cfg_data   (cfg_data),
    .fail_cnt   (fail_cnt),
    .open_cnt   (open_cnt),
    .checked_cnt(checked_cnt),
    .found_cnt  (found_cnt)
  );

  // receiver: segments of always ready, coin flip, sparse ready, or full stall
  always @(posedge clk) begin
    if (rx_left == 0) begin
      rx_kind <= $urandom_range(0, 3);
      rx_left <= $urandom_range(10, 200);
      out_tready <= 1'b1;
    end else begin
      rx_left <= rx_left - 1;
      case (rx_kind)
        0:       out_tready <= 1'b1;
        1:       out_tready <= 1'($urandom_range(0, 1));
        2:       out_tready <= ($urandom_range(0, 5) == 0);
        default: out_tready <= 1'b0;
      endcase
    end
  end

  always @(posedge clk) begin
    cycle_cnt <= cycle_cnt + 1;
    if (cycle_cnt == CYCLE_LIMIT) begin
      $display("TEST FAILED");
      $finish;
    end
  end

  task automatic send_request(input logic [2:0] ch, input logic [31:0] us,
      input logic en, input logic [2:0] pri);
    if (burst_left == 0) begin
      burst_left = $urandom_range(1, 12);
      if ($urandom_range(0, 3) != 0) begin
        in_tvalid <= 1'b0;
        repeat ($urandom_range(1, 150)) @(posedge clk);
      end
    end
    burst_left--;
    in_tdata <= {1'b0, pri, en, us, ch};
    in_tvalid <= 1'b1;
    do @(posedge clk); while (!in_tready);
  endtask

  task automatic wait_drained();
    in_tvalid <= 1'b0;
    burst_left = 0;
    do @(posedge clk); while (open_cnt != 0);
  endtask

  task automatic write_bus_clock(input logic [27:0] hz);
    cfg_data <= hz;
    cfg_valid <= 1'b1;
    do @(posedge clk); while (!cfg_ready);
    cfg_valid <= 1'b0;
  endtask

  function automatic logic [27:0] phase_clock(input int ph);
    case (ph)
      1:       return 28'd0;
      2:       return 28'd1;
      3:       return 28'd200_000_000;
      4:       return 28'hFFF_FFFF;
      5:       return 28'd1_000_000;
      6:       return 28'd40_000_000;
      default: return 28'($urandom_range(1, 200_000_000));
    endcase
  endfunction

  // log-spread periods, periods near a divisor's fit limit, raw words, tiny values
  function automatic logic [31:0] pick_period(input logic [27:0] hz);
    logic [63:0] limit_us;
    int unsigned sel;
    sel = $urandom_range(0, 9);
    if (sel < 4) return $urandom >> $urandom_range(0, 31);
    if (sel < 7 && hz != 0) begin
      limit_us = (64'd65536 * (64'd1 << $urandom_range(0, 8)) * 64'd1_000_000) / 64'(hz);
      limit_us = limit_us + 64'($urandom_range(0, 6)) - 64'd3;
      if (limit_us <= 64'hFFFF_FFFF) return limit_us[31:0];
    end
    if (sel < 9) return $urandom;
    return $urandom_range(0, 20);
  endfunction

  task automatic send_random_request();
    logic [2:0] ch;
    ch = ($urandom_range(0, 9) < 8) ? 3'($urandom_range(1, 5)) : 3'($urandom_range(0, 7));
    send_request(ch, pick_period(cur_hz), 1'($urandom_range(0, 1)),
                 3'($urandom_range(0, 7)));
  endtask

  initial begin
    repeat (5) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // bus clock at reset value: 80 ticks per us
    send_request(3'd0, 32'd1000, 1'b1, 3'd7);
    send_request(3'd6, 32'd1000, 1'b1, 3'd5);
    send_request(3'd7, 32'hFFFF_FFFF, 1'b1, 3'd7);
    send_request(3'd1, 32'd0, 1'b1, 3'd3);
    send_request(3'd2, 32'd0, 1'b0, 3'd1);
    send_request(3'd1, 32'd1, 1'b1, 3'd7);
    send_request(3'd1, 32'd819, 1'b0, 3'd2);
    send_request(3'd1, 32'd820, 1'b1, 3'd4);
    send_request(3'd1, 32'd50_000, 1'b1, 3'd6);
    send_request(3'd1, 32'd200_000, 1'b0, 3'd7);
    send_request(3'd1, 32'd300_000, 1'b1, 3'd7);
    send_request(3'd1, 32'hFFFF_FFFF, 1'b1, 3'd7);
    send_request(3'd2, 32'd1000, 1'b1, 3'd1);
    send_request(3'd3, 32'd3000, 1'b0, 3'd2);
    send_request(3'd4, 32'd6000, 1'b1, 3'd3);
    send_request(3'd5, 32'd12_000, 1'b1, 3'd4);
    send_request(3'd2, 32'd24_000, 1'b0, 3'd5);
    send_request(3'd3, 32'd48_000, 1'b1, 3'd6);
    send_request(3'd4, 32'd200_000, 1'b1, 3'd7);
    send_request(3'd5, 32'd210_000, 1'b1, 3'd7);
    send_request(3'd5, 32'hFFFF_FFFF, 1'b0, 3'd0);
    send_request(3'd2, 32'h8000_0000, 1'b1, 3'd2);
    send_request(3'd3, 32'h0000_FFFF, 1'b1, 3'd5);

    for (int ph = 0; ph < NUM_PHASES; ph++) begin
      if (ph > 0) begin
        wait_drained();
        cur_hz = phase_clock(ph);
        write_bus_clock(cur_hz);
      end
      for (int n = 0; n < REQ_PER_PHASE; n++) send_random_request();
    end

    wait_drained();
    repeat (DRAIN_CYCLES) @(posedge clk);

    if (open_cnt != 0) $error("%0d expected results never arrived", open_cnt);
    $display("Checked %0d results, %0d with a prescaler found, over %0d bus clock settings.",
             checked_cnt, found_cnt, NUM_PHASES);
    $display("Covered bad channels, zero ticks, no-fit periods and fit limits under idle/stall.");
    if (fail_cnt == 0 && open_cnt == 0) begin
      $display("TEST PASSED");
    end else begin
      $display("TEST FAILED");
    end
    $finish;
  end

endmodule
